>>> design/assert_macros.svh
// assertion helpers shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> design/mmac_pkg.sv
// types and constants for the matrix multiply-accumulate core
// no dependencies
package mmac_pkg;

	localparam int VAL_W       = 16;
	localparam int IDX_W       = 6;
	localparam int DIM_W       = 4;
	localparam int MODE_W      = 2;
	localparam int REG_IDX_W   = 3;
	localparam int STORE_DEPTH = 64;
	// sum of up to eight 16x16 products
	localparam int SUM_W       = 35;
	localparam int PROD_W      = VAL_W + SUM_W;
	localparam int ACC_W       = PROD_W + 1;
	localparam int FRAC_W      = 16;

	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_C = 2'd2;
	localparam logic [MODE_W-1:0] MODE_START  = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_ROWS_M      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS_N      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INNER_K     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_SCALE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BETA_SCALE  = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_MUL,
		S_ACC,
		S_ALPHA,
		S_BETA,
		S_SUM,
		S_RESULT,
		S_OUT
	} state_t;

	// zero counts as one, anything above the cap counts as the cap
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] cap);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > cap) begin
			r = cap;
		end
		return r;
	endfunction

endpackage

>>> design/matrix_multiply_accumulate_core.sv
// matrix multiply-accumulate core, C = alpha*A*B + beta*C in Q8.8
// depends on mmac_pkg, mmac_ram and assert_macros.svh
//
// Input channel (in_valid/in_ready) carries one word: mode, flat_index and
// element_value. Load words (A, B or C) write one store entry each; in_ready
// stays high while the core is idle, and in that state loads may arrive every cycle.
// A start word walks all M x N elements of C in row-major order. Each element
// runs K multiply-accumulates on the shared multiplier, each through S_RD,
// S_MUL and S_ACC, then scales by alpha in S_ALPHA and by beta in S_BETA, adds
// the two products and the rounding bias in S_BETA and S_SUM, and rounds and
// saturates into the output register in S_RESULT. The next element starts
// only once the result word is taken. The multiplier and the accumulator are shared.
// Output channel (out_valid/out_ready) carries out_index, out_value, saturated
// and last_result from an output register; while the receiver stalls the core
// holds that word and does no further work. in_ready stays low from the start
// word until the word marked last_result is taken.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// and must be made only while the core is idle; the core does not enforce this.
// Reset returns the registers to M = N = K = 8, alpha = 1.0, beta = 0 and
// clears store C through per-entry valid bits; stores A and B are not cleared.
`include "assert_macros.svh"

module matrix_multiply_accumulate_core import mmac_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [REG_IDX_W-1:0]        cfg_index,
	input  logic [VAL_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [MODE_W-1:0]           mode,
	input  logic [IDX_W-1:0]            flat_index,
	input  logic signed [VAL_W-1:0]     element_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [IDX_W-1:0]            out_index,
	output logic signed [VAL_W-1:0]     out_value,
	output logic                        saturated,
	output logic                        last_result
);

	localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
	localparam int CNT_W   = $clog2(DIM_CAP);
	localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);
	localparam int RND_W   = ACC_W - FRAC_W;

	state_t state_q, state_d;

	logic [DIM_W-1:0]        rows_m_q, cols_n_q, inner_k_q;
	logic signed [VAL_W-1:0] alpha_q, beta_q;
	logic [DIM_W-1:0]        m_eff, n_eff, k_eff;

	logic [CNT_W-1:0] i_q, j_q, p_q;
	logic [IDX_W-1:0] a_base_q, a_addr_q, b_addr_q, c_idx_q;
	logic             i_last, j_last, p_last;

	logic signed [PROD_W-1:0] prod_q, prod_d;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [VAL_W-1:0]  mul_x;
	logic signed [SUM_W-1:0]  mul_y;

	logic [VAL_W-1:0]        a_rdata, b_rdata, c_rdata;
	logic signed [VAL_W-1:0] a_rd, b_rd, c_eff;
	logic [STORE_DEPTH-1:0]  c_vld_q;

	logic                    in_acc, out_acc;
	logic                    a_we, b_we, c_we;
	logic [IDX_W-1:0]        c_waddr;
	logic [VAL_W-1:0]        c_wdata;

	logic signed [RND_W-1:0] rnd;
	logic                    sat_hi, sat_lo;
	logic signed [VAL_W-1:0] q_val;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	assign m_eff = clamp_dim(rows_m_q, DIM_CAP_V);
	assign n_eff = clamp_dim(cols_n_q, DIM_CAP_V);
	assign k_eff = clamp_dim(inner_k_q, DIM_CAP_V);

	assign i_last = (i_q == CNT_W'(m_eff - DIM_W'(1)));
	assign j_last = (j_q == CNT_W'(n_eff - DIM_W'(1)));
	assign p_last = (p_q == CNT_W'(k_eff - DIM_W'(1)));

	// stores
	assign a_we    = in_acc && (mode == MODE_LOAD_A);
	assign b_we    = in_acc && (mode == MODE_LOAD_B);
	assign c_we    = (in_acc && (mode == MODE_LOAD_C)) || (state_q == S_RESULT);
	assign c_waddr = (state_q == S_RESULT) ? c_idx_q : flat_index;
	assign c_wdata = (state_q == S_RESULT) ? q_val : element_value;

	mmac_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_store_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (flat_index),
		.wdata (element_value),
		.raddr (a_addr_q),
		.rdata (a_rdata)
	);

	mmac_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_store_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (flat_index),
		.wdata (element_value),
		.raddr (b_addr_q),
		.rdata (b_rdata)
	);

	mmac_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_store_c (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_idx_q),
		.rdata (c_rdata)
	);

	assign a_rd  = $signed(a_rdata);
	assign b_rd  = $signed(b_rdata);
	// an entry never written since reset reads as zero
	assign c_eff = c_vld_q[c_idx_q] ? $signed(c_rdata) : '0;

	// shared multiplier
	assign prod_d = mul_x * mul_y;

	// round to nearest (bias added earlier), then saturate
	assign rnd    = RND_W'(acc_q >>> FRAC_W);
	assign sat_hi = (rnd > RND_W'(32767));
	assign sat_lo = (rnd < -RND_W'(32768));
	assign q_val  = sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : rnd[VAL_W-1:0]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (mode == MODE_START)) begin
					state_d = S_RD;
				end
			end
			S_RD:     state_d = S_MUL;
			S_MUL:    state_d = S_ACC;
			S_ACC:    state_d = p_last ? S_ALPHA : S_RD;
			S_ALPHA:  state_d = S_BETA;
			S_BETA:   state_d = S_SUM;
			S_SUM:    state_d = S_RESULT;
			S_RESULT: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) begin
					state_d = last_result ? S_IDLE : S_RD;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mul_x     = '0;
		mul_y     = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_MUL: begin
				mul_x = a_rd;
				mul_y = SUM_W'(b_rd);
			end
			S_ALPHA: begin
				mul_x = alpha_q;
				mul_y = $signed(acc_q[SUM_W-1:0]);
			end
			S_BETA: begin
				mul_x = beta_q;
				mul_y = SUM_W'(c_eff);
			end
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= DIM_W'(8);
			cols_n_q  <= DIM_W'(8);
			inner_k_q <= DIM_W'(8);
			alpha_q   <= 16'sd256;
			beta_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROWS_M:      rows_m_q  <= cfg_data[DIM_W-1:0];
				REG_COLS_N:      cols_n_q  <= cfg_data[DIM_W-1:0];
				REG_INNER_K:     inner_k_q <= cfg_data[DIM_W-1:0];
				REG_ALPHA_SCALE: alpha_q   <= $signed(cfg_data);
				REG_BETA_SCALE:  beta_q    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// store C valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q <= '0;
		end else if (c_we) begin
			c_vld_q[c_waddr] <= 1'b1;
		end
	end

	// element walk counters and address generation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			p_q      <= '0;
			a_base_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			c_idx_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (mode == MODE_START)) begin
						i_q      <= '0;
						j_q      <= '0;
						p_q      <= '0;
						a_base_q <= '0;
						a_addr_q <= '0;
						b_addr_q <= '0;
						c_idx_q  <= '0;
					end
				end
				S_ACC: begin
					if (!p_last) begin
						p_q      <= p_q + 1'b1;
						a_addr_q <= a_addr_q + 1'b1;
						b_addr_q <= b_addr_q + IDX_W'(n_eff);
					end
				end
				S_OUT: begin
					if (out_ready && !last_result) begin
						p_q     <= '0;
						c_idx_q <= c_idx_q + 1'b1;
						if (j_last) begin
							// next row of C
							i_q      <= i_q + 1'b1;
							j_q      <= '0;
							a_base_q <= a_base_q + IDX_W'(k_eff);
							a_addr_q <= a_base_q + IDX_W'(k_eff);
							b_addr_q <= '0;
						end else begin
							j_q      <= j_q + 1'b1;
							a_addr_q <= a_base_q;
							b_addr_q <= IDX_W'(j_q) + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// accumulator and product registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: acc_q <= '0;
			S_MUL:  prod_q <= prod_d;
			S_ACC:  acc_q <= acc_q + ACC_W'(prod_q);
			S_ALPHA: prod_q <= prod_d;
			S_BETA: begin
				prod_q <= prod_d;
				acc_q  <= ACC_W'(prod_q) + ACC_W'(32768);
			end
			S_SUM:  acc_q <= acc_q + (ACC_W'(prod_q) <<< 8);
			S_OUT:  acc_q <= '0;
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == S_RESULT) begin
			out_index   <= c_idx_q;
			out_value   <= q_val;
			saturated   <= sat_hi || sat_lo;
			last_result <= i_last && j_last;
		end
	end

	`ASSERT_NEVER(a_in_out_excl, clk, arst_n, in_ready && out_valid,
		"input and output sides active together")
	`ASSERT_CLK(a_last_to_idle, clk, arst_n,
		out_valid && out_ready && last_result |=> in_ready,
		"core not idle after last result word")
	`ASSERT_CLK(a_next_element, clk, arst_n,
		out_valid && out_ready && !last_result |=> !in_ready && !out_valid,
		"run ended before last result word")
	`ASSERT_CLK(a_start_busy, clk, arst_n,
		in_valid && in_ready && mode == MODE_START |=> !in_ready && !out_valid,
		"start word did not begin a run")

endmodule

>>> design/mmac_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mmac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for matrix_multiply_accumulate_core, C = alpha*A*B + beta*C
// depends on mmac_pkg and the core; a small class predicts the C words and checks them

import mmac_pkg::*;

// usable dimension cap for the default MAX_DIM of 8
localparam int DIM_CAP = 8;

typedef struct {
	logic [IDX_W-1:0]        index;
	logic signed [VAL_W-1:0] value;
	logic                    clipped;
	logic                    is_last;
} c_word_t;

class gemm_checker;
	logic [DIM_W-1:0]        rows_m, cols_n, inner_k;
	logic signed [VAL_W-1:0] alpha_q, beta_q;
	logic signed [VAL_W-1:0] a_store [STORE_DEPTH];
	logic signed [VAL_W-1:0] b_store [STORE_DEPTH];
	logic signed [VAL_W-1:0] c_store [STORE_DEPTH];
	c_word_t                 expected_c [$];
	int                      errors;

	function new();
		rows_m  = 4'd8;
		cols_n  = 4'd8;
		inner_k = 4'd8;
		alpha_q = 16'sd256;
		beta_q  = '0;
		errors  = 0;
		foreach (c_store[i]) begin
			a_store[i] = '0;
			b_store[i] = '0;
			c_store[i] = '0;
		end
	endfunction

	function int unsigned used_dim(logic [DIM_W-1:0] raw);
		if (raw == '0) begin
			return 1;
		end
		if (raw > DIM_CAP) begin
			return DIM_CAP;
		end
		return raw;
	endfunction

	function int pending();
		return expected_c.size();
	endfunction

	function void write_reg(logic [REG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		case (idx)
			REG_ROWS_M:      rows_m  = data[DIM_W-1:0];
			REG_COLS_N:      cols_n  = data[DIM_W-1:0];
			REG_INNER_K:     inner_k = data[DIM_W-1:0];
			REG_ALPHA_SCALE: alpha_q = data;
			REG_BETA_SCALE:  beta_q  = data;
			default: ;
		endcase
	endfunction

	// walk C in row-major order, write back each new element
	function void compute_c_words();
		int unsigned m, n, k, ci;
		longint      dot, total, rounded;
		c_word_t     w;
		m = used_dim(rows_m);
		n = used_dim(cols_n);
		k = used_dim(inner_k);
		for (int unsigned i = 0; i < m; i++) begin
			for (int unsigned j = 0; j < n; j++) begin
				ci  = i * n + j;
				dot = 0;
				for (int unsigned p = 0; p < k; p++) begin
					dot += longint'(a_store[i * k + p]) * longint'(b_store[p * n + j]);
				end
				total = longint'(alpha_q) * dot
					+ longint'(beta_q) * longint'(c_store[ci]) * 256;
				// q24.24 to q8.8, half an lsb goes up
				rounded   = (total + 32768) >>> 16;
				w.clipped = 1'b0;
				if (rounded > 32767) begin
					rounded   = 32767;
					w.clipped = 1'b1;
				end else if (rounded < -32768) begin
					rounded   = -32768;
					w.clipped = 1'b1;
				end
				w.index     = ci[IDX_W-1:0];
				w.value     = rounded[VAL_W-1:0];
				w.is_last   = (i == m - 1) && (j == n - 1);
				c_store[ci] = rounded[VAL_W-1:0];
				expected_c.push_back(w);
			end
		end
	endfunction

	function void take_word(logic [MODE_W-1:0] md, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val);
		case (md)
			MODE_LOAD_A: a_store[idx] = val;
			MODE_LOAD_B: b_store[idx] = val;
			MODE_LOAD_C: c_store[idx] = val;
			default:     compute_c_words();
		endcase
	endfunction

	task report(string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task check_c_word(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
			logic clipped, logic is_last);
		c_word_t w;
		if (expected_c.size() == 0) begin
			report($sformatf("unexpected C word index %0d value %0d", idx, val));
			return;
		end
		w = expected_c.pop_front();
		if (idx !== w.index) begin
			report($sformatf("out_index %0d, expected %0d", idx, w.index));
		end
		if (val !== w.value) begin
			report($sformatf("out_value %0d at index %0d, expected %0d", val, w.index, w.value));
		end
		if (clipped !== w.clipped) begin
			report($sformatf("saturated %b at index %0d, expected %b", clipped, w.index,
				w.clipped));
		end
		if (is_last !== w.is_last) begin
			report($sformatf("last_result %b at index %0d, expected %b", is_last, w.index,
				w.is_last));
		end
	endtask
endclass

module tb;

	localparam int SETTLE_CYCLES = 3 * DIM_CAP + 5 + 11;
	localparam int HOLD_CYCLES   = 300;
	// about 100 runs of 64 words, each word with its compute time and a receiver stall, times eight
	localparam int CYCLE_LIMIT   = 2_000_000;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    cfg_wr_en     = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index     = '0;
	logic [VAL_W-1:0]        cfg_data      = '0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic [MODE_W-1:0]       mode          = '0;
	logic [IDX_W-1:0]        flat_index    = '0;
	logic signed [VAL_W-1:0] element_value = '0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic [IDX_W-1:0]        out_index;
	logic signed [VAL_W-1:0] out_value;
	logic                    saturated;
	logic                    last_result;

	gemm_checker gemm;
	bit          a_loaded [STORE_DEPTH];
	bit          b_loaded [STORE_DEPTH];
	bit          idle_on;
	int          hold_request;
	int          words_sent;
	int          cycle_count;

	matrix_multiply_accumulate_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.flat_index    (flat_index),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_index     (out_index),
		.out_value     (out_value),
		.saturated     (saturated),
		.last_result   (last_result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			gemm.check_c_word(out_index, out_value, saturated, last_result);
		end
	end

	// receiver: random stall bursts, or one long hold when asked
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				hold         = hold_request;
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("matrix_multiply_accumulate_core regression: fail");
		$finish;
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'h0100;
				endcase
			end
			1, 2, 3, 4, 5: return VAL_W'($urandom_range(0, 1023)) - 16'd512;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return VAL_W'($urandom);
			default: return VAL_W'($urandom_range(0, 767)) - 16'd384;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIM_W'($urandom_range(9, 15));
			2: return DIM_W'(8);
			default: return DIM_W'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_load_mode();
		case ($urandom_range(0, 2))
			0: return MODE_LOAD_A;
			1: return MODE_LOAD_B;
			default: return MODE_LOAD_C;
		endcase
	endfunction

	task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		gemm.write_reg(idx, data);
	endtask

	// dimension writes carry random upper bits that the core must drop
	task automatic configure(logic [DIM_W-1:0] m, logic [DIM_W-1:0] n, logic [DIM_W-1:0] k,
			logic [VAL_W-1:0] alpha, logic [VAL_W-1:0] beta);
		logic [VAL_W-1:0] pad;
		pad = VAL_W'($urandom);
		set_reg(REG_ROWS_M, {pad[VAL_W-1:DIM_W], m});
		pad = VAL_W'($urandom);
		set_reg(REG_COLS_N, {pad[VAL_W-1:DIM_W], n});
		pad = VAL_W'($urandom);
		set_reg(REG_INNER_K, {pad[VAL_W-1:DIM_W], k});
		set_reg(REG_ALPHA_SCALE, alpha);
		set_reg(REG_BETA_SCALE, beta);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_word(logic [MODE_W-1:0] md, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= md;
		flat_index    <= idx;
		element_value <= val;
		do @(posedge clk); while (!in_ready);
		gemm.take_word(md, idx, val);
		if (md == MODE_LOAD_A) begin
			a_loaded[idx] = 1'b1;
		end else if (md == MODE_LOAD_B) begin
			b_loaded[idx] = 1'b1;
		end
		words_sent++;
	endtask

	// A and B entries the shape reads get a value first, then the start word goes
	task automatic start_run(int hold);
		int unsigned m, n, k;
		m = gemm.used_dim(gemm.rows_m);
		n = gemm.used_dim(gemm.cols_n);
		k = gemm.used_dim(gemm.inner_k);
		for (int x = 0; x < m * k; x++) begin
			if (!a_loaded[x]) begin
				send_word(MODE_LOAD_A, IDX_W'(x), pick_value());
			end
		end
		for (int x = 0; x < k * n; x++) begin
			if (!b_loaded[x]) begin
				send_word(MODE_LOAD_B, IDX_W'(x), pick_value());
			end
		end
		hold_request = hold;
		send_word(MODE_START, IDX_W'($urandom), VAL_W'($urandom));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (gemm.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int               target, m, n, k, nloads, r;
		logic [MODE_W-1:0] md;
		target = words_sent + count;
		while (words_sent < target) begin
			m = gemm.used_dim(gemm.rows_m);
			n = gemm.used_dim(gemm.cols_n);
			k = gemm.used_dim(gemm.inner_k);
			r = $urandom_range(0, 9);
			if (r < 7) begin
				// loads inside the used shape followed by a start
				nloads = $urandom_range(1, 6);
				repeat (nloads) begin
					md = pick_load_mode();
					case (md)
						MODE_LOAD_A: send_word(md, IDX_W'($urandom_range(0, m * k - 1)),
							pick_value());
						MODE_LOAD_B: send_word(md, IDX_W'($urandom_range(0, k * n - 1)),
							pick_value());
						default: send_word(md, IDX_W'($urandom_range(0, m * n - 1)),
							pick_value());
					endcase
				end
				start_run(0);
			end else if (r < 9) begin
				send_word(pick_load_mode(), IDX_W'($urandom), pick_value());
			end else begin
				start_run(0);
			end
		end
	endtask

	initial begin
		gemm         = new();
		idle_on      = 1'b1;
		hold_request = 0;
		words_sent   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element: saturation both ways and rounding of half an lsb
		configure(4'd1, 4'd1, 4'd1, 16'h0100, 16'h0000);
		send_word(MODE_LOAD_A, 6'd0, 16'h7fff);
		send_word(MODE_LOAD_B, 6'd0, 16'h7fff);
		start_run(0);
		send_word(MODE_LOAD_A, 6'd0, 16'h8000);
		start_run(0);
		send_word(MODE_LOAD_B, 6'd0, 16'h8000);
		start_run(0);
		send_word(MODE_LOAD_A, 6'd0, 16'h0001);
		send_word(MODE_LOAD_B, 6'd0, 16'h0080);
		start_run(0);
		send_word(MODE_LOAD_A, 6'd0, 16'hffff);
		start_run(0);
		// C written outside the shape stays until a larger shape covers it
		send_word(MODE_LOAD_C, 6'd63, 16'h8000);
		send_word(MODE_LOAD_C, 6'd0, 16'h7fff);
		settle();

		// beta only, at its negative extreme
		configure(4'd1, 4'd1, 4'd1, 16'h0000, 16'h8000);
		start_run(0);
		start_run(0);
		settle();

		// zero dimensions count as one, oversize ones as the cap
		configure(4'd0, 4'd15, 4'd0, 16'h7fff, 16'h7fff);
		start_run(0);
		settle();

		// long output hold while the next word waits at the input
		configure(4'd8, 4'd8, 4'd1, 16'h0100, 16'h0080);
		start_run(HOLD_CYCLES);
		repeat (4) send_word(pick_load_mode(), IDX_W'($urandom), pick_value());
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			idle_on = (ph < 10) && ($urandom_range(0, 3) != 0);
			if (ph == 0) begin
				configure(4'd8, 4'd8, 4'd8, pick_scale(), pick_scale());
			end else begin
				configure(pick_dim(), pick_dim(), pick_dim(), pick_scale(), pick_scale());
			end
			random_phase(28);
			settle();
		end

		if (gemm.errors == 0) begin
			$display("matrix_multiply_accumulate_core regression: pass");
		end else begin
			$display("matrix_multiply_accumulate_core regression: fail");
		end
		$finish;
	end

endmodule
